// File: hdl/assert_macros.svh
// Assertion macros shared by the validator RTL.
// Each macro samples on the rising clock edge and is disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define USV_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("usv assertion failed");

// Consequent holds in the cycle after the antecedent.
`define USV_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("usv assertion failed");

`endif

// File: hdl/usv_pkg.sv
// Types and constants for the UTF-8 stream validator.
// No dependencies; imported by usv_step and the top level.
`default_nettype none

package usv_pkg;

   localparam logic [7:0] ASCII_MAX  = 8'h7F;
   localparam logic [7:0] CONT_MIN   = 8'h80;
   localparam logic [7:0] CONT_MAX   = 8'hBF;
   localparam logic [7:0] LEAD2_MIN  = 8'hC0;
   localparam logic [7:0] LEAD2_MAX  = 8'hDF;
   localparam logic [7:0] LEAD3_MIN  = 8'hE0;
   localparam logic [7:0] LEAD3_MAX  = 8'hEF;
   localparam logic [7:0] LEAD4_MIN  = 8'hF0;
   localparam logic [7:0] LEAD4_MAX  = 8'hF4;

   localparam int DATA_BITS   = 8;
   localparam int STATUS_BITS = 2;
   localparam int ERRPOS_BITS = 32;
   localparam int RSP_BITS    = 40;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_RUNNING = 2'd0,
      STATUS_VALID   = 2'd1,
      STATUS_INVALID = 2'd2
   } status_type;

   typedef struct packed {
      logic [1:0] pending;
      logic       error_seen;
   } ctrl_type;

endpackage

`default_nettype wire

// File: hdl/utf8_stream_validator_top.sv
// UTF-8 stream validator: one byte per beat in, one status beat out.
// The result is registered and presented in the cycle after the byte beat is taken.
// Throughput: one byte per cycle unless rsp_tready stalls; a single result register
// with tready bypass sets the pace: a new byte is taken when the result slot drains.
// Reset: synchronous, active high; clears pending count, position and error.
// Depends on usv_pkg, usv_step and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module utf8_stream_validator_top #(
   parameter int POSITION_BITS = 32
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [usv_pkg::DATA_BITS-1:0]     req_tdata,  // [7:0] data_byte
   input  wire logic                              req_tlast,  // last_byte
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [usv_pkg::RSP_BITS-1:0]           rsp_tdata   // [1:0] status,
                                                              // [33:2] error_position
);
   import usv_pkg::*;

   ctrl_type                 ctrl_ff, ctrl_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [POSITION_BITS-1:0] epos_ff, epos_in;
   logic                     valid_ff;
   status_type               status_ff, status_in;
   logic [ERRPOS_BITS-1:0]   errpos_ff, errpos_in;
   logic                     req_fire;

   assign req_tready = !valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   usv_step #(
      .POSITION_BITS(POSITION_BITS)
   ) u_step (
      .data_byte      (req_tdata),
      .last_byte      (req_tlast),
      .ctrl           (ctrl_ff),
      .position       (pos_ff),
      .error_pos      (epos_ff),
      .ctrl_next      (ctrl_in),
      .position_next  (pos_in),
      .error_pos_next (epos_in),
      .status         (status_in),
      .error_position (errpos_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff  <= '0;
         pos_ff   <= '0;
         epos_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            ctrl_ff  <= ctrl_in;
            pos_ff   <= pos_in;
            epos_ff  <= epos_in;
            valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         status_ff <= status_in;
         errpos_ff <= errpos_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {{(RSP_BITS - ERRPOS_BITS - STATUS_BITS){1'b0}}, errpos_ff, status_ff};

   `USV_ASSERT_NEXT(a_last_clears, req_fire && req_tlast,
      (ctrl_ff == '0) && (pos_ff == '0) && (epos_ff == '0))
   `USV_ASSERT_NEXT(a_error_sticks, ctrl_ff.error_seen && !(req_fire && req_tlast),
      ctrl_ff.error_seen && $stable(epos_ff))
   `USV_ASSERT_NOW(a_status_code, valid_ff,
      (status_ff == STATUS_RUNNING) || (status_ff == STATUS_VALID) ||
      (status_ff == STATUS_INVALID))
   `USV_ASSERT_NOW(a_clean_pos_zero, valid_ff && (status_ff != STATUS_INVALID),
      errpos_ff == '0)

endmodule

`default_nettype wire

// File: hdl/usv_step.sv
// Per-byte decode step: classifies one byte against the current state.
// Depends on usv_pkg; purely combinational.
`default_nettype none

module usv_step #(
   parameter int POSITION_BITS = 32
) (
   input  wire logic [usv_pkg::DATA_BITS-1:0]   data_byte,
   input  wire logic                            last_byte,
   input  wire usv_pkg::ctrl_type               ctrl,
   input  wire logic [POSITION_BITS-1:0]        position,
   input  wire logic [POSITION_BITS-1:0]        error_pos,
   output usv_pkg::ctrl_type                    ctrl_next,
   output logic [POSITION_BITS-1:0]             position_next,
   output logic [POSITION_BITS-1:0]             error_pos_next,
   output usv_pkg::status_type                  status,
   output logic [usv_pkg::ERRPOS_BITS-1:0]      error_position
);
   import usv_pkg::*;

   localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

   logic [POSITION_BITS-1:0] pos;
   logic [POSITION_BITS-1:0] pos_after;
   logic                     is_cont;
   logic [1:0]               pend_w;
   logic                     err_w;
   logic [POSITION_BITS-1:0] epos_w;

   assign pos       = (position == POS_MAX) ? position : position + 1'b1;
   assign pos_after = (pos == POS_MAX) ? pos : pos + 1'b1;
   assign is_cont   = (data_byte >= CONT_MIN) && (data_byte <= CONT_MAX);

   always_comb begin
      pend_w = ctrl.pending;
      err_w  = ctrl.error_seen;
      epos_w = error_pos;
      if (!ctrl.error_seen) begin
         if (ctrl.pending != 2'd0) begin
            if (is_cont) begin
               pend_w = ctrl.pending - 2'd1;
            end else begin
               err_w  = 1'b1;
               epos_w = pos;
            end
         end else if (data_byte <= ASCII_MAX) begin
            pend_w = 2'd0;
         end else if (data_byte inside {[LEAD2_MIN:LEAD2_MAX]}) begin
            pend_w = 2'd1;
         end else if (data_byte inside {[LEAD3_MIN:LEAD3_MAX]}) begin
            pend_w = 2'd2;
         end else if (data_byte inside {[LEAD4_MIN:LEAD4_MAX]}) begin
            pend_w = 2'd3;
         end else begin
            err_w  = 1'b1;
            epos_w = pos;
         end
         if (last_byte && !err_w && (pend_w != 2'd0)) begin
            err_w  = 1'b1;
            epos_w = pos_after;
         end
      end
   end

   always_comb begin
      if (err_w) begin
         status         = STATUS_INVALID;
         error_position = ERRPOS_BITS'(epos_w);
      end else begin
         status         = last_byte ? STATUS_VALID : STATUS_RUNNING;
         error_position = '0;
      end
   end

   always_comb begin
      if (last_byte) begin
         ctrl_next      = '0;
         position_next  = '0;
         error_pos_next = '0;
      end else begin
         ctrl_next.pending    = pend_w;
         ctrl_next.error_seen = err_w;
         position_next        = ctrl.error_seen ? position : pos;
         error_pos_next       = epos_w;
      end
   end

endmodule

`default_nettype wire

// File: tb/tb_utf8_stream_validator_top.sv
// Self-checking testbench for utf8_stream_validator_top: byte streams in, status beats out.
// A scoreboard class predicts the status of every accepted byte; tasks drive the request side.
// Depends on usv_pkg and the validator RTL.
`default_nettype none

module tb_utf8_stream_validator_top;
   import usv_pkg::*;

   class utf8_status_scoreboard;
      typedef struct {
         status_type  status;
         logic [31:0] error_position;
      } status_beat_type;

      status_beat_type expected_q[$];
      logic [1:0]      cont_left;
      logic [31:0]     pos_count;
      bit              err_latched;
      logic [31:0]     err_pos;
      int              failures;
      int              results_checked;
      int              streams_valid;
      int              streams_invalid;

      function new();
         clear_stream();
         failures        = 0;
         results_checked = 0;
         streams_valid   = 0;
         streams_invalid = 0;
      endfunction

      function void clear_stream();
         cont_left   = '0;
         pos_count   = '0;
         err_latched = 1'b0;
         err_pos     = '0;
      endfunction

      function logic [31:0] sat_next(logic [31:0] v);
         return (v == '1) ? v : v + 32'd1;
      endfunction

      function void latch_error(logic [31:0] p);
         err_latched = 1'b1;
         err_pos     = p;
      endfunction

      function void note_byte(logic [7:0] b, logic last);
         logic [31:0]     p;
         status_beat_type e;
         if (!err_latched) begin
            p         = sat_next(pos_count);
            pos_count = p;
            if (cont_left != 0) begin
               if (b >= CONT_MIN && b <= CONT_MAX)
                  cont_left = cont_left - 2'd1;
               else
                  latch_error(p);
            end else if (b <= ASCII_MAX) begin
               cont_left = 2'd0;
            end else if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
               cont_left = 2'd1;
            end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
               cont_left = 2'd2;
            end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
               cont_left = 2'd3;
            end else begin
               latch_error(p);
            end
            if (last && !err_latched && cont_left != 0)
               latch_error(sat_next(p));
         end
         if (err_latched) begin
            e.status         = STATUS_INVALID;
            e.error_position = err_pos;
         end else begin
            e.status         = last ? STATUS_VALID : STATUS_RUNNING;
            e.error_position = '0;
         end
         expected_q.push_back(e);
         if (last) begin
            if (err_latched)
               streams_invalid++;
            else
               streams_valid++;
            clear_stream();
         end
      endfunction

      function void check_status(logic [RSP_BITS-1:0] word);
         status_beat_type e;
         logic [STATUS_BITS-1:0] got_status;
         logic [ERRPOS_BITS-1:0] got_pos;
         got_status = word[STATUS_BITS-1:0];
         got_pos    = word[STATUS_BITS +: ERRPOS_BITS];
         results_checked++;
         if (expected_q.size() == 0) begin
            failures++;
            $display("%0t: unexpected result beat, expected none, actual status %0d position %0d",
                     $time, got_status, got_pos);
            return;
         end
         e = expected_q.pop_front();
         if (got_status !== e.status) begin
            failures++;
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, e.status, got_status);
         end
         if (got_pos !== e.error_position) begin
            failures++;
            $display("%0t: error_position mismatch, expected %0d, actual %0d",
                     $time, e.error_position, got_pos);
         end
      endfunction
   endclass

   localparam int CYCLE_LIMIT   = 500000;
   localparam int RANDOM_BYTES  = 1900;
   localparam int LONG_HOLD     = 90;

   logic                    clock;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [DATA_BITS-1:0]    req_tdata  = '0;
   logic                    req_tlast  = 1'b0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_BITS-1:0]     rsp_tdata;

   int                      idle_mode    = 0;
   int                      hold_request = 0;
   int                      cycle_count  = 0;
   int                      beats_sent   = 0;
   logic [7:0]              stream_q[$];
   utf8_status_scoreboard   sb = new();

   utf8_stream_validator_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_status(rsp_tdata);
   end

   function automatic int draw_gap();
      case (idle_mode)
         0: return 0;
         1: return ($urandom_range(0, 4) == 0) ? $urandom_range(0, 17) : 0;
         default: return $urandom_range(0, 17);
      endcase
   endfunction

   function automatic logic [7:0] any_cont();
      return 8'($urandom_range(CONT_MIN, CONT_MAX));
   endfunction

   function automatic logic [7:0] non_cont();
      return $urandom_range(0, 1) ? 8'($urandom_range(0, ASCII_MAX))
                                  : 8'($urandom_range(LEAD2_MIN, 8'hFF));
   endfunction

   function automatic logic [7:0] lead_for(int conts);
      case (conts)
         0: return 8'($urandom_range(0, ASCII_MAX));
         1: return 8'($urandom_range(LEAD2_MIN, LEAD2_MAX));
         2: return 8'($urandom_range(LEAD3_MIN, LEAD3_MAX));
         default: return 8'($urandom_range(LEAD4_MIN, LEAD4_MAX));
      endcase
   endfunction

   function automatic void push_char();
      int k;
      k = $urandom_range(0, 3);
      stream_q.push_back(lead_for(k));
      repeat (k) stream_q.push_back(any_cont());
   endfunction

   function automatic void build_random_stream();
      int kind;
      int idx;
      int k;
      kind = $urandom_range(0, 19);
      if (kind == 19) begin
         repeat ($urandom_range(1, 12)) stream_q.push_back(8'($urandom_range(0, 255)));
         return;
      end
      repeat (($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8))
         push_char();
      if (kind == 14 || kind == 15) begin
         idx = $urandom_range(0, stream_q.size() - 1);
         stream_q.insert(idx, $urandom_range(0, 1) ? any_cont()
                                                   : 8'($urandom_range(8'hF5, 8'hFF)));
      end else if (kind == 16 || kind == 17) begin
         idx = $urandom_range(0, stream_q.size());
         stream_q.insert(idx, non_cont());
         stream_q.insert(idx, lead_for($urandom_range(1, 3)));
      end else if (kind == 18) begin
         k = $urandom_range(1, 3);
         stream_q.push_back(lead_for(k));
         repeat ($urandom_range(0, k - 1)) stream_q.push_back(any_cont());
      end
   endfunction

   task automatic send_beat(logic [7:0] b, logic last);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      sb.note_byte(b, last);
      beats_sent++;
   endtask

   task automatic send_stream();
      int i;
      for (i = 0; i < stream_q.size(); i++)
         send_beat(stream_q[i], i == stream_q.size() - 1);
      stream_q.delete();
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.expected_q.size() != 0);
   endtask

   initial begin
      int stall;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = draw_gap();
         if (hold_request > 0) begin
            stall        = hold_request;
            hold_request = 0;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   initial begin
      int start_beats;
      int streams;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      stream_q = '{8'h00, LEAD2_MIN, CONT_MIN, LEAD3_MAX, CONT_MAX, CONT_MAX,
                   LEAD4_MIN, CONT_MIN, CONT_MIN, CONT_MIN};
      send_stream();
      stream_q = '{ASCII_MAX};
      send_stream();
      stream_q = '{LEAD2_MAX, 8'h41, 8'h42, 8'hFF};
      send_stream();
      stream_q = '{8'hF5};
      send_stream();
      stream_q = '{LEAD3_MIN, CONT_MIN};
      send_stream();
      stream_q = '{CONT_MIN};
      send_stream();
      stream_q = '{LEAD4_MAX, CONT_MAX};
      send_stream();
      stream_q = '{8'h20, 8'hFF, 8'h41};
      send_stream();
      drain();

      // stall the result side while bytes keep coming
      hold_request = LONG_HOLD;
      repeat (12) push_char();
      send_stream();
      drain();

      start_beats = beats_sent;
      streams     = 0;
      while (beats_sent - start_beats < RANDOM_BYTES) begin
         if (streams % 12 == 0)
            idle_mode = (idle_mode + 1) % 3;
         if (streams == 150) begin
            idle_mode    = 0;
            hold_request = LONG_HOLD;
         end
         build_random_stream();
         send_stream();
         streams++;
         if ($urandom_range(0, 29) == 0)
            drain();
      end
      drain();
      repeat (8) @(posedge clock);

      $display("Sent %0d bytes; %0d streams ended valid, %0d invalid; %0d status beats checked",
               beats_sent, sb.streams_valid, sb.streams_invalid, sb.results_checked);
      $display("Covered lead classes, bad and truncated sequences, long output stalls and pauses");
      if (sb.failures == 0 && sb.expected_q.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0t: %0d mismatches, %0d status beats never arrived",
                  $time, sb.failures, sb.expected_q.size());
         $display("Verification failed");
      end
      $finish;
   end
endmodule

`default_nettype wire
